// ===== rtl/pip_pkg.sv =====
// shared types and constants for the polygon inclusion and area block
// no dependencies
`default_nettype none
package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 24;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int AREA_W       = 2 * COORD_BITS;
  localparam int SUM_W        = 2 * COORD_BITS + 2 + CNT_W;
  localparam int HALF_W       = 50;
  localparam int ACT_W        = 2;

  localparam logic signed [SUM_W-1:0] HALF_MAX =
    SUM_W'((64'sd1 <<< (HALF_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] HALF_MIN = -HALF_MAX - SUM_W'(1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [CNT_W-1:0]             cnt_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  // one closed edge from prev vertex (1) to current vertex (2), with the query point
  typedef struct packed {
    logic   valid;
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
    coord_t px;
    coord_t py;
  } edge_t;

  typedef struct packed {
    logic                     parity;
    logic                     hit;
    logic signed [SUM_W-1:0]  sum;
  } acc_t;

endpackage
`default_nettype wire

// ===== rtl/pip_if.sv =====
// valid/ready channel interfaces for input items and result items
// depends on pip_pkg
`default_nettype none
interface pip_in_if;
  import pip_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  coord_t              coord_x;
  coord_t              coord_y;
  logic                edge_inclusive;
  modport source (output valid, action, coord_x, coord_y, edge_inclusive, input ready);
  modport sink   (input valid, action, coord_x, coord_y, edge_inclusive, output ready);
endinterface

interface pip_out_if;
  import pip_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     inside_res;
  logic signed [HALF_W-1:0] half_area;
  logic [CNT_W-1:0]         vertex_total;
  logic                     status;
  modport source (output valid, inside_res, half_area, vertex_total, status, input ready);
  modport sink   (input valid, inside_res, half_area, vertex_total, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/pip_cell.sv =====
// one vertex cell of the rotating vertex ring
// depends on pip_pkg
`default_nettype none
module pip_cell (
  input  wire logic            clk_i,
  input  wire logic            shift_i,
  input  wire pip_pkg::coord_t nxt_x_i,
  input  wire pip_pkg::coord_t nxt_y_i,
  input  wire logic            wr_i,
  input  wire pip_pkg::coord_t wr_x_i,
  input  wire pip_pkg::coord_t wr_y_i,
  output pip_pkg::coord_t      x_o,
  output pip_pkg::coord_t      y_o
);
  import pip_pkg::*;

  coord_t x_q, y_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      x_q <= wr_x_i;
      y_q <= wr_y_i;
    end else if (shift_i) begin
      x_q <= nxt_x_i;
      y_q <= nxt_y_i;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule
`default_nettype wire

// ===== rtl/pip_edge_unit.sv =====
// pipelined edge evaluator: crossing test, on-edge test and shoelace term
// depends on pip_pkg
`default_nettype none
module pip_edge_unit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           clr_i,
  input  wire pip_pkg::edge_t edge_i,
  output pip_pkg::acc_t       acc_o
);
  import pip_pkg::*;

  logic signed [DIFF_W-1:0] dx, dy, qx, qy, ady;
  logic                     spans, box;

  logic                     v1_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q, qx_q, qy_q, ady_q;
  logic                     neg_q, spans_q, box_q;
  coord_t                   x1_q, y1_q, x2_q, y2_q;

  logic                     v2_q;
  logic signed [PROD_W-1:0] a_q, b_q, c_q;
  logic signed [AREA_W-1:0] m1_q, m2_q;
  logic                     neg2_q, spans2_q, box2_q;

  logic                     crossed, on_edge;
  logic signed [SUM_W-1:0]  term;
  acc_t                     acc_q;

  always_comb begin
    dx  = DIFF_W'(edge_i.x2) - DIFF_W'(edge_i.x1);
    dy  = DIFF_W'(edge_i.y2) - DIFF_W'(edge_i.y1);
    qx  = DIFF_W'(edge_i.px) - DIFF_W'(edge_i.x1);
    qy  = DIFF_W'(edge_i.py) - DIFF_W'(edge_i.y1);
    ady = dy[DIFF_W-1] ? -dy : dy;
    spans = (edge_i.y1 <= edge_i.py && edge_i.py < edge_i.y2) ||
            (edge_i.y2 <= edge_i.py && edge_i.py < edge_i.y1);
    box = ((edge_i.x1 <= edge_i.px && edge_i.px <= edge_i.x2) ||
           (edge_i.x2 <= edge_i.px && edge_i.px <= edge_i.x1)) &&
          ((edge_i.y1 <= edge_i.py && edge_i.py <= edge_i.y2) ||
           (edge_i.y2 <= edge_i.py && edge_i.py <= edge_i.y1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= edge_i.valid;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q    <= dx;
    dy_q    <= dy;
    qx_q    <= qx;
    qy_q    <= qy;
    ady_q   <= ady;
    neg_q   <= dy[DIFF_W-1];
    spans_q <= spans;
    box_q   <= box;
    x1_q    <= edge_i.x1;
    y1_q    <= edge_i.y1;
    x2_q    <= edge_i.x2;
    y2_q    <= edge_i.y2;
  end

  always_ff @(posedge clk_i) begin
    a_q      <= PROD_W'(qx_q) * PROD_W'(ady_q);
    b_q      <= PROD_W'(dx_q) * PROD_W'(qy_q);
    c_q      <= PROD_W'(dy_q) * PROD_W'(qx_q);
    m1_q     <= AREA_W'(x2_q) * AREA_W'(y1_q);
    m2_q     <= AREA_W'(x1_q) * AREA_W'(y2_q);
    neg2_q   <= neg_q;
    spans2_q <= spans_q;
    box2_q   <= box_q;
  end

  always_comb begin
    crossed = spans2_q && (neg2_q ? (a_q < -b_q) : (a_q < b_q));
    on_edge = box2_q && (b_q == c_q);
    term    = SUM_W'(m1_q) - SUM_W'(m2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (clr_i) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q.parity <= acc_q.parity ^ crossed;
      acc_q.hit    <= acc_q.hit | (!crossed && on_edge);
      acc_q.sum    <= acc_q.sum + term;
    end
  end

  assign acc_o = acc_q;

endmodule
`default_nettype wire

// ===== rtl/polygon_point_inclusion_and_area.sv =====
// after a transaction is accepted, the vertex ring rotates once past the edge unit, one edge per
// cycle, then the edge pipeline drains and the result waits for the output register to be free
// one transaction at a time; the next is accepted once the last result is in the output register
// a result waiting in the output register does not block acceptance, only the next result
// reset empties the polygon (vertex count zero); vertex cells are not cleared
// depends on pip_pkg, pip_if, pip_cell, pip_edge_unit
`default_nettype none
module polygon_point_inclusion_and_area (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pip_in_if.sink    in_i,
  pip_out_if.source out_o
);
  import pip_pkg::*;

  state_e                  state_q, state_d;
  cnt_t                    count_q, count_d;
  cnt_t                    step_q;
  logic [1:0]              drain_q;
  logic [ACT_W-1:0]        act_q;
  coord_t                  px_q, py_q, first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic                    incl_q, status_q;
  logic                    accept, append_ok, shift, out_load;

  coord_t                  cx [MAX_VERTICES];
  coord_t                  cy [MAX_VERTICES];

  edge_t                   edge_w;
  acc_t                    acc;
  logic signed [SUM_W-1:0] half, half_sat;

  logic                    ov_q, oin_q, ost_q;
  logic signed [HALF_W-1:0] oha_q;
  cnt_t                    ocnt_q;

  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign append_ok = (action_e'(in_i.action) == ACT_APPEND) && (count_q < cnt_t'(MAX_VERTICES));
  assign shift     = (state_q == ST_WALK) && (step_q < cnt_t'(MAX_VERTICES));

  for (genvar gi = 0; gi < MAX_VERTICES; gi++) begin : g_ring
    pip_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .nxt_x_i (cx[(gi + 1) % MAX_VERTICES]),
      .nxt_y_i (cy[(gi + 1) % MAX_VERTICES]),
      .wr_i    (accept && append_ok && (count_q[IDX_W-1:0] == IDX_W'(gi))),
      .wr_x_i  (in_i.coord_x),
      .wr_y_i  (in_i.coord_y),
      .x_o     (cx[gi]),
      .y_o     (cy[gi])
    );
  end

  // closing edge wraps back to the first vertex
  always_comb begin
    edge_w.valid = (state_q == ST_WALK) && (step_q != '0) && (step_q <= count_q);
    edge_w.x1    = prev_x_q;
    edge_w.y1    = prev_y_q;
    edge_w.x2    = (step_q == count_q) ? first_x_q : cx[0];
    edge_w.y2    = (step_q == count_q) ? first_y_q : cy[0];
    edge_w.px    = px_q;
    edge_w.py    = py_q;
  end

  pip_edge_unit u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (accept),
    .edge_i (edge_w),
    .acc_o  (acc)
  );

  always_comb begin
    count_d = count_q;
    if (accept) begin
      case (action_e'(in_i.action))
        ACT_CLEAR:  count_d = '0;
        ACT_APPEND: if (append_ok) count_d = count_q + cnt_t'(1);
        default:    count_d = count_q;
      endcase
    end
  end

  assign out_load = (state_q == ST_DONE) && (!ov_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_WALK;
      ST_WALK:  if (step_q == cnt_t'(MAX_VERTICES)) state_d = ST_DRAIN;
      ST_DRAIN: if (drain_q == 2'd2) state_d = ST_DONE;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      step_q  <= '0;
      drain_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (accept) step_q <= '0;
      else if (state_q == ST_WALK && step_q != cnt_t'(MAX_VERTICES)) step_q <= step_q + cnt_t'(1);
      if (state_q == ST_DRAIN) drain_q <= drain_q + 2'd1;
      else drain_q <= '0;
      if (out_load) ov_q <= 1'b1;
      else if (out_o.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q    <= in_i.action;
      px_q     <= in_i.coord_x;
      py_q     <= in_i.coord_y;
      incl_q   <= in_i.edge_inclusive;
      status_q <= (action_e'(in_i.action) == ACT_APPEND) && !append_ok;
    end
    if (state_q == ST_WALK) begin
      if (step_q == '0) begin
        first_x_q <= cx[0];
        first_y_q <= cy[0];
      end
      prev_x_q <= cx[0];
      prev_y_q <= cy[0];
    end
  end

  // halve toward zero, then saturate to the result field
  always_comb begin
    half = (acc.sum + $signed({{(SUM_W-1){1'b0}}, acc.sum[SUM_W-1]})) >>> 1;
    if (half > HALF_MAX) half_sat = HALF_MAX;
    else if (half < HALF_MIN) half_sat = HALF_MIN;
    else half_sat = half;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      oin_q  <= (action_e'(act_q) == ACT_QUERY) && ((incl_q && acc.hit) || acc.parity);
      oha_q  <= half_sat[HALF_W-1:0];
      ocnt_q <= count_q;
      ost_q  <= status_q;
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.inside_res   = oin_q;
  assign out_o.half_area    = oha_q;
  assign out_o.vertex_total = ocnt_q;
  assign out_o.status       = ost_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(MAX_VERTICES))
    else $error("vertex count beyond store depth");

  a_status_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status |-> out_o.vertex_total == cnt_t'(MAX_VERTICES))
    else $error("dropped append reported with room in store");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK || state_q == ST_DRAIN) |-> !in_i.ready)
    else $error("input ready during edge walk");

  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |=> $stable(count_q))
    else $error("vertex count changed during edge walk");

endmodule
`default_nettype wire
